FILE: design/drc_pkg.sv
package drc_pkg;

   localparam int PAYLOAD_MAX   = 64;
   localparam int PAYLOAD_START = 36;
   localparam int CRC_START     = 100;
   localparam int RECORD_BYTES  = 104;

   localparam int POS_W   = $clog2(RECORD_BYTES);
   localparam int PIDX_W  = 6;
   localparam int Q_DEPTH = 4;
   localparam int QPTR_W  = $clog2(Q_DEPTH);

   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [15:0] VERSION_RESET = 16'd1;

   localparam logic [7:0] MAGIC [4] = '{8'h58, 8'h33, 8'h44, 8'h47};

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_MAGIC    = 3'd1;
   localparam logic [2:0] STATUS_VERSION  = 3'd2;
   localparam logic [2:0] STATUS_LENGTH   = 3'd3;
   localparam logic [2:0] STATUS_CRC      = 3'd4;

   typedef struct packed {
      logic [7:0]       data;
      logic [POS_W-1:0] pos;
      logic             is_last;
      logic             in_crc;
      logic             in_payload;
      logic [POS_W-1:0] payload_idx;
   } item_type;

   typedef struct packed {
      logic        is_verdict;
      logic [7:0]  payload_byte;
      logic [5:0]  payload_index;
      logic [2:0]  status;
      logic [15:0] event_code;
      logic [15:0] payload_count;
      logic [15:0] flag_bits;
      logic [31:0] sequence_number;
      logic [31:0] boot_number;
      logic [63:0] uptime_ms;
      logic [63:0] clock_seconds;
   } result_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

   function automatic logic [63:0] put_lane(input logic [63:0] v, input logic [2:0] lane,
                                             input logic [7:0] b);
      logic [63:0] r;
      r = v;
      r[lane*8 +: 8] = b;
      return r;
   endfunction

endpackage

FILE: design/diagnostic_record_checker_top.sv
// Accepted bytes enter the queue; a result is registered as its byte is popped.
// Throughput: one byte per cycle unless the queue is full or rsp_ready stalls;
// the back end's byte-wide CRC update and field capture are combinational.
// A four-entry queue separates the front end from the back end.
// Reset is synchronous and active high; it clears the record state and the queue,
// and sets expected_version to 1.
module diagnostic_record_checker_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_expected_version,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_verdict,
   output logic [7:0]  rsp_payload_byte,
   output logic [5:0]  rsp_payload_index,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_event_code,
   output logic [15:0] rsp_payload_count,
   output logic [15:0] rsp_flag_bits,
   output logic [31:0] rsp_sequence_number,
   output logic [31:0] rsp_boot_number,
   output logic [63:0] rsp_uptime_ms,
   output logic [63:0] rsp_clock_seconds
);
   import drc_pkg::*;

   logic [15:0] version_ff;
   logic        q_full;
   logic        q_push;
   item_type    push_item;
   logic        q_pop;
   logic        q_not_empty;
   item_type    head_item;
   result_type  result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_RESET;
      end else if (csr_valid && csr_ready) begin
         version_ff <= csr_expected_version;
      end
   end

   drc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (push_item)
   );

   drc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   drc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .expected_version (version_ff),
      .q_not_empty      (q_not_empty),
      .q_item           (head_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result       (result)
   );

   assign rsp_is_verdict      = result.is_verdict;
   assign rsp_payload_byte    = result.payload_byte;
   assign rsp_payload_index   = result.payload_index;
   assign rsp_status          = result.status;
   assign rsp_event_code      = result.event_code;
   assign rsp_payload_count   = result.payload_count;
   assign rsp_flag_bits       = result.flag_bits;
   assign rsp_sequence_number = result.sequence_number;
   assign rsp_boot_number     = result.boot_number;
   assign rsp_uptime_ms       = result.uptime_ms;
   assign rsp_clock_seconds   = result.clock_seconds;

endmodule

FILE: design/drc_front.sv
module drc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              q_full,
   output logic              q_push,
   output drc_pkg::item_type q_item
);
   import drc_pkg::*;

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] pidx;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;
   assign pidx      = pos_ff - POS_W'(PAYLOAD_START);

   always_comb begin
      q_item.data        = req_data_byte;
      q_item.pos         = pos_ff;
      q_item.is_last     = (pos_ff == POS_W'(RECORD_BYTES - 1));
      q_item.in_crc      = (pos_ff < POS_W'(CRC_START));
      q_item.in_payload  = (pos_ff >= POS_W'(PAYLOAD_START)) && (pos_ff < POS_W'(CRC_START))
                           && (pidx < POS_W'(PAYLOAD_MAX));
      q_item.payload_idx = pidx;
   end

   always_comb begin
      pos_in = pos_ff;
      if (q_push) begin
         if (pos_ff == POS_W'(RECORD_BYTES - 1)) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

FILE: design/drc_queue.sv
module drc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  drc_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output drc_pkg::item_type head_item
);
   import drc_pkg::*;

   item_type          slot_ff [Q_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;
   logic [QPTR_W:0]   count_in;

   assign full      = (count_ff == (QPTR_W+1)'(Q_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

endmodule

FILE: design/drc_back.sv
module drc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [15:0]         expected_version,
   input  logic                q_not_empty,
   input  drc_pkg::item_type   q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output drc_pkg::result_type rsp_result
);
   import drc_pkg::*;

   logic [31:0] crc_ff, crc_in;
   logic        magic_ff, magic_in;
   logic [15:0] version_ff, version_in;
   logic [15:0] event_ff, event_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] flags_ff, flags_in;
   logic [31:0] sequence_ff, sequence_in;
   logic [31:0] boot_ff, boot_in;
   logic [63:0] uptime_ff, uptime_in;
   logic [63:0] clock_ff, clock_in;
   logic [31:0] crc_recv_ff, crc_recv_in;

   logic        rsp_valid_ff;
   result_type  rsp_ff;
   logic        produce;
   result_type  result;
   logic [POS_W-1:0] p;
   logic [7:0]  b;

   assign q_pop      = q_not_empty && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;
   assign p          = q_item.pos;
   assign b          = q_item.data;

   always_comb begin
      magic_in    = magic_ff;
      version_in  = version_ff;
      event_in    = event_ff;
      length_in   = length_ff;
      flags_in    = flags_ff;
      sequence_in = sequence_ff;
      boot_in     = boot_ff;
      uptime_in   = uptime_ff;
      clock_in    = clock_ff;
      crc_in      = crc_ff;
      crc_recv_in = crc_recv_ff;
      if (p < POS_W'(4)) begin
         if (b != MAGIC[p[1:0]]) begin
            magic_in = 1'b0;
         end
      end else if (p < POS_W'(6)) begin
         version_in = 16'(put_lane(64'(version_ff), 3'(p - POS_W'(4)), b));
      end else if (p < POS_W'(8)) begin
         event_in = 16'(put_lane(64'(event_ff), 3'(p - POS_W'(6)), b));
      end else if (p < POS_W'(10)) begin
         length_in = 16'(put_lane(64'(length_ff), 3'(p - POS_W'(8)), b));
      end else if (p < POS_W'(12)) begin
         flags_in = 16'(put_lane(64'(flags_ff), 3'(p - POS_W'(10)), b));
      end else if (p < POS_W'(16)) begin
         sequence_in = 32'(put_lane(64'(sequence_ff), 3'(p - POS_W'(12)), b));
      end else if (p < POS_W'(20)) begin
         boot_in = 32'(put_lane(64'(boot_ff), 3'(p - POS_W'(16)), b));
      end else if (p < POS_W'(28)) begin
         uptime_in = put_lane(uptime_ff, 3'(p - POS_W'(20)), b);
      end else if (p < POS_W'(36)) begin
         clock_in = put_lane(clock_ff, 3'(p - POS_W'(28)), b);
      end
      if (q_item.in_crc) begin
         crc_in = crc_byte(crc_ff, b);
      end else if (p < POS_W'(CRC_START + 4)) begin
         crc_recv_in = 32'(put_lane(64'(crc_recv_ff), 3'(p - POS_W'(CRC_START)), b));
      end
   end

   always_comb begin
      result  = '0;
      produce = 1'b0;
      if (q_item.is_last) begin
         produce                = 1'b1;
         result.is_verdict      = 1'b1;
         result.event_code      = event_in;
         result.payload_count   = length_in;
         result.flag_bits       = flags_in;
         result.sequence_number = sequence_in;
         result.boot_number     = boot_in;
         result.uptime_ms       = uptime_in;
         result.clock_seconds   = clock_in;
         if (!magic_in) begin
            result.status = STATUS_MAGIC;
         end else if (version_in != expected_version) begin
            result.status = STATUS_VERSION;
         end else if (length_in > 16'(PAYLOAD_MAX)) begin
            result.status = STATUS_LENGTH;
         end else if (~crc_in != crc_recv_in) begin
            result.status = STATUS_CRC;
         end else begin
            result.status = STATUS_OK;
         end
      end else if (q_item.in_payload && (16'(q_item.payload_idx) < length_ff)) begin
         produce              = 1'b1;
         result.payload_byte  = b;
         result.payload_index = q_item.payload_idx[PIDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= produce;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (q_pop && q_item.is_last)) begin
         crc_ff      <= CRC_INIT;
         magic_ff    <= 1'b1;
         version_ff  <= '0;
         event_ff    <= '0;
         length_ff   <= '0;
         flags_ff    <= '0;
         sequence_ff <= '0;
         boot_ff     <= '0;
         uptime_ff   <= '0;
         clock_ff    <= '0;
         crc_recv_ff <= '0;
      end else if (q_pop) begin
         crc_ff      <= crc_in;
         magic_ff    <= magic_in;
         version_ff  <= version_in;
         event_ff    <= event_in;
         length_ff   <= length_in;
         flags_ff    <= flags_in;
         sequence_ff <= sequence_in;
         boot_ff     <= boot_in;
         uptime_ff   <= uptime_in;
         clock_ff    <= clock_in;
         crc_recv_ff <= crc_recv_in;
      end
   end

endmodule
